// File: rtl/core/utf8_to_ucs2_decoder_core_assert.svh
// assertion macros for the utf8 to ucs2 decoder core
// expects signals clk and rst in the scope where a macro is used
`ifndef UTF8_TO_UCS2_DECODER_CORE_ASSERT_SVH
`define UTF8_TO_UCS2_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define U8DEC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8dec assertion failed");

// next-cycle implication, checked outside reset
`define U8DEC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8dec assertion failed");

`endif

// File: rtl/core/u8dec_pkg.sv
// shared types and constants for the utf8 to ucs2 decoder core
// no dependencies
package u8dec_pkg;

  typedef enum logic [1:0] {
    ST_CHAR      = 2'd0,
    ST_SUPP      = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_TRUNC     = 2'd3
  } status_t;

  localparam logic [7:0] ASCII_MAX     = 8'h7F;
  localparam logic [7:0] LEAD2_MIN     = 8'hC2;
  localparam logic [7:0] LEAD2_MAX     = 8'hDF;
  localparam logic [7:0] LEAD3_MIN     = 8'hE0;
  localparam logic [7:0] LEAD3_MAX     = 8'hEF;
  localparam logic [7:0] LEAD4_MIN     = 8'hF0;
  localparam logic [7:0] LEAD4_MAX     = 8'hF4;
  localparam logic [7:0] CONT_MIN      = 8'h80;
  localparam logic [7:0] CONT_MAX      = 8'hBF;
  localparam logic [7:0] LEAD2_MASK    = 8'h1F;
  localparam logic [7:0] CONT_MASK     = 8'h3F;
  localparam logic [7:0] LEAD3_MASK    = 8'h0F;

  // decoder state carried between items
  typedef struct packed {
    logic [1:0]  pending;
    logic [15:0] partial;
    logic        four_byte;
  } dec_state_t;

  // result of one decode step
  typedef struct packed {
    logic        valid;
    logic [15:0] code_unit;
    status_t     status;
  } dec_result_t;

endpackage

// File: rtl/core/u8dec_step.sv
// one decode step: next state and optional result for one byte
// depends on u8dec_pkg
module u8dec_step
  import u8dec_pkg::*;
(
  input  dec_state_t  cur,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  output dec_state_t  nxt,
  output dec_result_t res
);

  localparam dec_state_t IDLE_STATE = '{pending: 2'd0, partial: 16'd0, four_byte: 1'b0};

  logic        is_cont;
  logic [1:0]  pend_dec;
  logic [15:0] shifted;

  assign is_cont  = (data_byte >= CONT_MIN) && (data_byte <= CONT_MAX);
  assign pend_dec = cur.pending - 2'd1;
  assign shifted  = {cur.partial[9:0], data_byte[5:0] & CONT_MASK[5:0]};

  always_comb begin
    nxt           = cur;
    res.valid     = 1'b0;
    res.code_unit = 16'd0;
    res.status    = ST_CHAR;
    if (cur.pending == 2'd0) begin
      unique case (data_byte) inside
        [8'h00:ASCII_MAX]: begin
          res.valid     = 1'b1;
          res.code_unit = {8'd0, data_byte};
        end
        [LEAD2_MIN:LEAD2_MAX]: begin
          nxt = '{pending: 2'd1, partial: {8'd0, data_byte & LEAD2_MASK}, four_byte: 1'b0};
        end
        [LEAD3_MIN:LEAD3_MAX]: begin
          nxt = '{pending: 2'd2, partial: {8'd0, data_byte & LEAD3_MASK}, four_byte: 1'b0};
        end
        [LEAD4_MIN:LEAD4_MAX]: begin
          nxt = '{pending: 2'd3, partial: 16'd0, four_byte: 1'b1};
        end
        default: begin
          res.valid  = 1'b1;
          res.status = ST_MALFORMED;
        end
      endcase
    end else if (!is_cont) begin
      nxt        = IDLE_STATE;
      res.valid  = 1'b1;
      res.status = ST_MALFORMED;
    end else if (pend_dec == 2'd0) begin
      // sequence complete
      nxt       = IDLE_STATE;
      res.valid = 1'b1;
      if (cur.four_byte) begin
        res.status = ST_SUPP;
      end else begin
        res.code_unit = shifted;
      end
    end else begin
      nxt.pending = pend_dec;
      if (!cur.four_byte) begin
        nxt.partial = shifted;
      end
    end

    // sequence still open at the last byte of the buffer
    if (end_of_buffer && !res.valid && nxt.pending != 2'd0) begin
      nxt        = IDLE_STATE;
      res.valid  = 1'b1;
      res.status = ST_TRUNC;
    end
  end

endmodule

// File: rtl/core/utf8_to_ucs2_decoder_core.sv
// channel   dir  tdata             tuser    tlast
// s_axis    in   data_byte[7:0]    -        end_of_buffer
// m_axis    out  code_unit[15:0]   status   -
//
// one byte per cycle sustained while m_axis is not stalled; a taken byte sits in the input register
// and is decoded into the result register, from which its item is offered on m_axis
// reset clears the decoder state and both valid flags; no result is pending
// a stalled m_axis holds the result register and, behind it, the input register
// zero or one item per byte: only completing, rejecting or truncating bytes emit
// depends on u8dec_pkg, u8dec_step and utf8_to_ucs2_decoder_core_assert.svh
module utf8_to_ucs2_decoder_core
  import u8dec_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] code_unit
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  dec_state_t  state;
  dec_state_t  state_next;
  dec_result_t step_res;
  logic        out_valid;
  logic [15:0] out_code;
  status_t     out_status;
  logic        out_free;
  logic        advance;

  assign out_free      = !out_valid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  u8dec_step u_step (
    .cur           (state),
    .data_byte     (in_byte),
    .end_of_buffer (in_last),
    .nxt           (state_next),
    .res           (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{pending: 2'd0, partial: 16'd0, four_byte: 1'b0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && step_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res.valid) begin
      out_code   <= step_res.code_unit;
      out_status <= step_res.status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_code;
  assign m_axis_tuser  = out_status;

`include "utf8_to_ucs2_decoder_core_assert.svh"

  `U8DEC_ASSERT_NOW(a_code_zero_unless_char, out_valid && out_status != ST_CHAR, out_code == 16'd0)
  `U8DEC_ASSERT_NOW(a_four_byte_no_value, state.four_byte, state.partial == 16'd0 && state.pending != 2'd0)
  `U8DEC_ASSERT_NEXT(a_idle_after_last, advance && in_last, state.pending == 2'd0)
  `U8DEC_ASSERT_NEXT(a_stall_keeps_input, in_valid && !out_free, in_valid && $stable(in_byte))

endmodule
